### rtl/core/key_autofire_slot_engine_core_defines.svh
// Assertion helpers used by the kas_back core module.
`ifndef KEY_AUTOFIRE_SLOT_ENGINE_CORE_DEFINES_SVH
`define KEY_AUTOFIRE_SLOT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KAS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define KAS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/kas_pkg.sv
package kas_pkg;

	localparam logic [1:0] CMD_DOWN = 2'd0;
	localparam logic [1:0] CMD_UP   = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic [1:0] KIND_PRESS   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_FULL    = 2'd2;

	localparam logic [31:0] DEFAULT_SEED = 32'hA5A5A5A5;
	localparam int          CNT_W        = 17;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  position;
		logic [31:0] keycode;
		logic [31:0] seed_mix;
	} item_t;

	function automatic logic [31:0] kas_draw(input logic [31:0] cur, input logic [31:0] fb);
		logic [31:0] x;
		x = cur;
		if (x == 32'd0) begin
			x = (fb == 32'd0) ? DEFAULT_SEED : fb;
		end
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

endpackage

### rtl/core/key_autofire_slot_engine_core.sv
// A key down passes states IDLE, FIND and ALLOC, a key up IDLE and UP, and a tick walks
// the slots in index order. A randomized delay is drawn by a serial remainder, one bit
// per cycle. The back end pops a new event only in IDLE, so one event finishes before the
// next starts; a two-entry front queue buffers arrivals, and out_stall can hold results.
// Reset (arst_n low) clears all slots and the generator and restores register defaults.
module key_autofire_slot_engine_core
	import kas_pkg::*;
#(
	parameter int MAX_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  position,
	input  logic [31:0] keycode,
	input  logic [31:0] seed_mix,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] out_keycode,
	output logic [7:0]  out_position,
	output logic        last
);

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	kas_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.position (position),
		.keycode  (keycode),
		.seed_mix (seed_mix),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	kas_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_item       (q_item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.out_keycode  (out_keycode),
		.out_position (out_position),
		.last         (last)
	);

endmodule

### rtl/core/kas_front.sv
module kas_front
	import kas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  position,
	input  logic [31:0] keycode,
	input  logic [31:0] seed_mix,
	output logic        q_valid,
	input  logic        q_pop,
	output item_t       q_item
);

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_stall = (cnt_q == 2'd2);
	// drop unknown commands at the door
	assign push     = in_valid && !in_stall && (command != 2'd3);
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{command: command, position: position,
				keycode: keycode, seed_mix: seed_mix};
		end
	end

endmodule

### rtl/core/kas_mod.sv
module kas_mod
	import kas_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      num,
	input  logic [CNT_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [CNT_W-1:0] rem
);

	logic [31:0]      num_q;
	logic [CNT_W-1:0] rem_q;
	logic [4:0]       step_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] den_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;

	assign trial = {rem_q, num_q[31]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 5'd0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= (trial >= {1'b0, den_q}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

endmodule

### rtl/core/kas_back.sv
module kas_back
	import kas_pkg::*;
#(
	parameter int MAX_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  item_t       q_item,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] out_keycode,
	output logic [7:0]  out_position,
	output logic        last
);

	localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIND  = 3'd1;
	localparam logic [2:0] ST_ALLOC = 3'd2;
	localparam logic [2:0] ST_UP    = 3'd3;
	localparam logic [2:0] ST_TICK  = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;

	localparam logic [2:0] REG_TAP_MIN  = 3'd0;
	localparam logic [2:0] REG_TAP_MAX  = 3'd1;
	localparam logic [2:0] REG_WAIT_MIN = 3'd2;
	localparam logic [2:0] REG_WAIT_MAX = 3'd3;
	localparam logic [2:0] REG_SEED     = 3'd4;

	logic [15:0] tap_min_q, tap_max_q, wait_min_q, wait_max_q;
	logic [31:0] seed_q;
	logic [31:0] prng_q;

	logic [MAX_SLOTS-1:0] active_q;
	logic [MAX_SLOTS-1:0] down_q;
	logic [CNT_W-1:0]     cnt_q  [MAX_SLOTS];
	logic [7:0]           pos_q  [MAX_SLOTS];
	logic [31:0]          code_q [MAX_SLOTS];

	logic [2:0]    st_q;
	logic [2:0]    ret_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] sel_q;
	logic [15:0]   lo_q;
	item_t         cur_q;

	logic             ov_q;
	logic [1:0]       kind_q;
	logic [31:0]      code_o_q;
	logic [7:0]       pos_o_q;
	logic             last_q;
	logic             out_free;
	logic             ld_out;

	logic             hit;
	logic [IW-1:0]    hit_idx;
	logic             has_free;
	logic [IW-1:0]    free_idx;
	logic             later_exp;
	logic [IW-1:0]    ti;
	logic [CNT_W-1:0] nc;
	logic [31:0]      drawn;
	logic [15:0]      dlo, dhi;
	logic [CNT_W-1:0] span;

	logic             mod_start;
	logic             mod_busy;
	logic             mod_done;
	logic [CNT_W-1:0] mod_rem;

	assign out_free = !ov_q || !out_stall;
	assign ti       = idx_q[IW-1:0];
	assign drawn    = kas_draw(prng_q, seed_q);

	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		has_free = 1'b0;
		free_idx = '0;
		later_exp = 1'b0;
		for (int j = 0; j < MAX_SLOTS; j++) begin
			if (!hit && active_q[j] && pos_q[j] == cur_q.position) begin
				hit     = 1'b1;
				hit_idx = IW'(j);
			end
			if (!has_free && !active_q[j]) begin
				has_free = 1'b1;
				free_idx = IW'(j);
			end
			if (j > int'(idx_q) && active_q[j] && cnt_q[j] <= CNT_W'(1)) begin
				later_exp = 1'b1;
			end
		end
	end

	assign nc = (cnt_q[ti] != '0) ? cnt_q[ti] - CNT_W'(1) : '0;

	always_comb begin
		dlo = tap_min_q;
		dhi = tap_max_q;
		if (st_q == ST_TICK && down_q[ti]) begin
			dlo = wait_min_q;
			dhi = wait_max_q;
		end
	end
	assign span = {1'b0, dhi} - {1'b0, dlo} + CNT_W'(1);

	always_comb begin
		mod_start = 1'b0;
		q_pop     = 1'b0;
		ld_out    = 1'b0;
		unique case (st_q)
			ST_IDLE:  q_pop = q_valid;
			ST_FIND, ST_UP: ld_out = hit && down_q[hit_idx] && out_free;
			ST_ALLOC: begin
				mod_start = out_free && has_free && (dhi > dlo);
				ld_out    = out_free;
			end
			ST_TICK: begin
				ld_out    = idx_q != CW'(MAX_SLOTS) && active_q[ti] && nc == '0 && out_free;
				mod_start = ld_out && (dhi > dlo);
			end
			default: ;
		endcase
	end

	kas_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.num    (drawn),
		.den    (span),
		.busy   (mod_busy),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_min_q  <= 16'd20;
			tap_max_q  <= 16'd20;
			wait_min_q <= 16'd40;
			wait_max_q <= 16'd40;
			seed_q     <= DEFAULT_SEED;
			prng_q     <= '0;
			active_q   <= '0;
			down_q     <= '0;
			for (int j = 0; j < MAX_SLOTS; j++) cnt_q[j] <= '0;
			st_q  <= ST_IDLE;
			ret_q <= ST_IDLE;
			idx_q <= '0;
			sel_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TAP_MIN:  tap_min_q  <= cfg_data[15:0];
					REG_TAP_MAX:  tap_max_q  <= cfg_data[15:0];
					REG_WAIT_MIN: wait_min_q <= cfg_data[15:0];
					REG_WAIT_MAX: wait_max_q <= cfg_data[15:0];
					REG_SEED:     seed_q     <= cfg_data;
					default: ;
				endcase
			end
			ov_q <= ld_out || (ov_q && out_stall);
			if (mod_start) prng_q <= drawn;

			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						idx_q <= '0;
						unique case (q_item.command)
							CMD_DOWN: begin
								prng_q <= prng_q ^ q_item.seed_mix ^ {8'd0, q_item.position, 16'd0};
								st_q   <= ST_FIND;
							end
							CMD_UP:  st_q <= ST_UP;
							default: st_q <= ST_TICK;
						endcase
					end
				end
				ST_FIND, ST_UP: begin
					if (!hit) begin
						st_q <= (st_q == ST_FIND) ? ST_ALLOC : ST_IDLE;
					end else if (!down_q[hit_idx] || out_free) begin
						active_q[hit_idx] <= 1'b0;
						down_q[hit_idx]   <= 1'b0;
						cnt_q[hit_idx]    <= '0;
						st_q <= (st_q == ST_FIND) ? ST_ALLOC : ST_IDLE;
					end
				end
				ST_ALLOC: begin
					if (out_free) begin
						if (has_free) begin
							active_q[free_idx] <= 1'b1;
							down_q[free_idx]   <= 1'b1;
							if (dhi > dlo) begin
								sel_q <= free_idx;
								lo_q  <= dlo;
								ret_q <= ST_IDLE;
								st_q  <= ST_DIV;
							end else begin
								cnt_q[free_idx] <= {1'b0, dlo};
								st_q <= ST_IDLE;
							end
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_TICK: begin
					if (idx_q == CW'(MAX_SLOTS)) begin
						st_q <= ST_IDLE;
					end else if (!active_q[ti]) begin
						idx_q <= idx_q + CW'(1);
					end else if (nc != '0) begin
						cnt_q[ti] <= nc;
						idx_q <= idx_q + CW'(1);
					end else if (out_free) begin
						down_q[ti] <= ~down_q[ti];
						idx_q      <= idx_q + CW'(1);
						if (dhi > dlo) begin
							sel_q <= ti;
							lo_q  <= dlo;
							ret_q <= ST_TICK;
							st_q  <= ST_DIV;
						end else begin
							cnt_q[ti] <= {1'b0, dlo};
						end
					end
				end
				ST_DIV: begin
					if (mod_done) begin
						cnt_q[sel_q] <= {1'b0, lo_q} + mod_rem;
						st_q <= ret_q;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_item;
		unique case (st_q)
			ST_FIND, ST_UP: begin
				if (hit && down_q[hit_idx] && out_free) begin
					kind_q   <= KIND_RELEASE;
					code_o_q <= code_q[hit_idx];
					pos_o_q  <= pos_q[hit_idx];
					last_q   <= (st_q == ST_UP);
				end
			end
			ST_ALLOC: begin
				if (out_free) begin
					kind_q   <= has_free ? KIND_PRESS : KIND_FULL;
					code_o_q <= cur_q.keycode;
					pos_o_q  <= cur_q.position;
					last_q   <= 1'b1;
					if (has_free) begin
						pos_q[free_idx]  <= cur_q.position;
						code_q[free_idx] <= cur_q.keycode;
					end
				end
			end
			ST_TICK: begin
				if (idx_q != CW'(MAX_SLOTS) && active_q[ti] && nc == '0 && out_free) begin
					kind_q   <= down_q[ti] ? KIND_RELEASE : KIND_PRESS;
					code_o_q <= code_q[ti];
					pos_o_q  <= pos_q[ti];
					last_q   <= !later_exp;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = ov_q;
	assign kind         = kind_q;
	assign out_keycode  = code_o_q;
	assign out_position = pos_o_q;
	assign last         = last_q;

`include "key_autofire_slot_engine_core_defines.svh"

	`KAS_ASSERT_IMP(a_idle_no_div, st_q == ST_IDLE, !mod_busy, "divider busy while idle")
	`KAS_ASSERT_IMP(a_idx_range, 1'b1, idx_q <= CW'(MAX_SLOTS), "slot walk index out of range")
	`KAS_ASSERT_IMP(a_down_active, 1'b1, (down_q & ~active_q) == '0, "free slot marked down")
	`KAS_ASSERT_NXT(a_div_start, mod_start, st_q == ST_DIV, "delay draw without wait state")

endmodule

### dv/kas_tb_pkg.sv
package kas_tb_pkg;

	localparam logic [2:0] REG_TAP_MIN   = 3'd0;
	localparam logic [2:0] REG_TAP_MAX   = 3'd1;
	localparam logic [2:0] REG_WAIT_MIN  = 3'd2;
	localparam logic [2:0] REG_WAIT_MAX  = 3'd3;
	localparam logic [2:0] REG_FALLBACK  = 3'd4;

	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] code;
		logic [7:0]  pos;
		logic        last;
	} fire_t;

endpackage

### dv/kas_checker.sv
module kas_checker
	import kas_pkg::*;
	import kas_tb_pkg::*;
#(
	parameter int NSLOT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  position,
	input  logic [31:0] keycode,
	input  logic [31:0] seed_mix,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] out_keycode,
	input  logic [7:0]  out_position,
	input  logic        last,
	output int          fails,
	output int          pending
);

	logic [15:0] tap_lo, tap_hi, wait_lo, wait_hi;
	logic [31:0] fb_seed;
	logic        busy [NSLOT];
	logic        down [NSLOT];
	logic [7:0]  spos [NSLOT];
	logic [31:0] scode [NSLOT];
	logic [16:0] cnt [NSLOT];
	logic [31:0] rng;
	fire_t       fires_due[$];

	assign pending = fires_due.size();

	function automatic logic [31:0] next_rng();
		logic [31:0] x;
		x = rng;
		if (x == 0)
			x = (fb_seed == 0) ? 32'hA5A5A5A5 : fb_seed;
		x ^= x << 13;
		x ^= x >> 17;
		x ^= x << 5;
		rng = x;
		return x;
	endfunction

	function automatic logic [16:0] delay_in(logic [15:0] lo, logic [15:0] hi);
		logic [32:0] span;
		if (hi <= lo)
			return {1'b0, lo};
		span = {17'd0, hi} - {17'd0, lo} + 33'd1;
		return 17'({1'b0, next_rng()} % span) + {1'b0, lo};
	endfunction

	function automatic void push_fire(logic [1:0] k, logic [31:0] c, logic [7:0] p);
		fire_t f;
		f.kind = k;
		f.code = c;
		f.pos = p;
		f.last = 1'b0;
		fires_due.push_back(f);
	endfunction

	function automatic int slot_of(logic [7:0] p);
		for (int i = 0; i < NSLOT; i++)
			if (busy[i] && spos[i] == p)
				return i;
		return -1;
	endfunction

	function automatic void drop_slot(int i);
		if (down[i])
			push_fire(KIND_RELEASE, scode[i], spos[i]);
		busy[i] = 0;
		down[i] = 0;
		cnt[i] = 0;
	endfunction

	function automatic void predict(logic [1:0] c, logic [7:0] p, logic [31:0] k,
			logic [31:0] m);
		int n0;
		int i;
		n0 = fires_due.size();
		if (c == CMD_DOWN) begin
			rng ^= m ^ ({24'd0, p} << 16);
			i = slot_of(p);
			if (i >= 0)
				drop_slot(i);
			i = 0;
			while (i < NSLOT && busy[i])
				i++;
			if (i == NSLOT) begin
				push_fire(KIND_FULL, k, p);
			end else begin
				busy[i] = 1;
				down[i] = 1;
				spos[i] = p;
				scode[i] = k;
				push_fire(KIND_PRESS, k, p);
				cnt[i] = delay_in(tap_lo, tap_hi);
			end
		end else if (c == CMD_UP) begin
			i = slot_of(p);
			if (i >= 0)
				drop_slot(i);
		end else if (c == CMD_TICK) begin
			for (int j = 0; j < NSLOT; j++) begin
				if (busy[j]) begin
					if (cnt[j] != 0)
						cnt[j]--;
					if (cnt[j] == 0) begin
						if (down[j]) begin
							down[j] = 0;
							push_fire(KIND_RELEASE, scode[j], spos[j]);
							cnt[j] = delay_in(wait_lo, wait_hi);
						end else begin
							down[j] = 1;
							push_fire(KIND_PRESS, scode[j], spos[j]);
							cnt[j] = delay_in(tap_lo, tap_hi);
						end
					end
				end
			end
		end
		if (fires_due.size() > n0)
			fires_due[fires_due.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_lo = 20;
			tap_hi = 20;
			wait_lo = 40;
			wait_hi = 40;
			fb_seed = 32'hA5A5A5A5;
			rng = 0;
			for (int i = 0; i < NSLOT; i++) begin
				busy[i] = 0;
				down[i] = 0;
				cnt[i] = 0;
			end
			fires_due.delete();
			fails = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TAP_MIN: tap_lo = cfg_data[15:0];
					REG_TAP_MAX: tap_hi = cfg_data[15:0];
					REG_WAIT_MIN: wait_lo = cfg_data[15:0];
					REG_WAIT_MAX: wait_hi = cfg_data[15:0];
					REG_FALLBACK: fb_seed = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (fires_due.size() == 0) begin
					$error("unexpected transfer kind %0d code %h pos %0d",
						kind, out_keycode, out_position);
					fails++;
				end else begin
					fire_t e;
					e = fires_due.pop_front();
					if (kind !== e.kind) begin
						$error("kind expected %0d actual %0d", e.kind, kind);
						fails++;
					end
					if (out_keycode !== e.code) begin
						$error("out_keycode expected %h actual %h", e.code, out_keycode);
						fails++;
					end
					if (out_position !== e.pos) begin
						$error("out_position expected %0d actual %0d", e.pos, out_position);
						fails++;
					end
					if (last !== e.last) begin
						$error("last expected %0d actual %0d", e.last, last);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict(command, position, keycode, seed_mix);
		end
	end

endmodule

### dv/tb.sv
module tb;
	import kas_pkg::*;
	import kas_tb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  command;
	logic [7:0]  position;
	logic [31:0] keycode;
	logic [31:0] seed_mix;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [31:0] out_keycode;
	logic [7:0]  out_position;
	logic        last;
	int          fails;
	int          pending;
	bit          steady;

	key_autofire_slot_engine_core u_dut (.*);

	kas_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	function automatic int gap_len();
		if (steady)
			return 0;
		if ($urandom_range(0, 9) < 6)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	int stall_left;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_left <= gap_len();
		end
		if (stall_left == 1)
			out_stall <= 1'b0;
		else if (stall_left == 0)
			out_stall <= !steady && $urandom_range(0, 3) == 0;
	end

	task automatic send(logic [1:0] c, logic [7:0] p, logic [31:0] k, logic [31:0] m);
		int g;
		in_valid <= 1'b1;
		command <= c;
		position <= p;
		keycode <= k;
		seed_mix <= m;
		do @(posedge clk); while (in_stall);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_ranges(logic [31:0] tl, logic [31:0] th, logic [31:0] wl,
			logic [31:0] wh, logic [31:0] fb);
		set_reg(REG_TAP_MIN, tl);
		set_reg(REG_TAP_MAX, th);
		set_reg(REG_WAIT_MIN, wl);
		set_reg(REG_WAIT_MAX, wh);
		set_reg(REG_FALLBACK, fb);
	endtask

	task automatic random_run(int n);
		logic [1:0] c;
		logic [7:0] p;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			c = (r < 55) ? CMD_TICK : (r < 80) ? CMD_DOWN : (r < 96) ? CMD_UP : CMD_NONE;
			p = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
			send(c, p, $urandom, $urandom);
			if (i == n / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		command = CMD_TICK;
		position = 0;
		keycode = 0;
		seed_mix = 0;
		cfg_we = 0;
		cfg_index = REG_TAP_MIN;
		cfg_data = 0;
		out_stall = 0;
		stall_left = 0;
		steady = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_DOWN, 8'd0, 32'h0, 32'h0);
		send(CMD_DOWN, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send(CMD_UP, 8'd0, 32'h0, 32'h0);
		send(CMD_UP, 8'd0, 32'h0, 32'h0);
		send(CMD_NONE, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF);
		settle();
		set_ranges(0, 3, 0, 2, 32'h0);
		for (int i = 1; i <= 8; i++)
			send(CMD_DOWN, 8'(i), $urandom, $urandom);
		send(CMD_DOWN, 8'd9, 32'h12345678, $urandom);
		send(CMD_DOWN, 8'd3, 32'hCAFEF00D, $urandom);
		repeat (6) send(CMD_TICK, 8'd0, 32'h0, 32'h0);
		send(CMD_UP, 8'd2, 32'h0, 32'h0);
		send(CMD_UP, 8'd77, 32'h0, 32'h0);
		settle();

		steady = 1;
		set_ranges(1, 5, 0, 4, 32'h1);
		random_run(44);
		settle();
		steady = 0;
		set_ranges(0, 0, 0, 0, 32'hFFFFFFFF);
		random_run(44);
		settle();
		set_ranges(6, 2, 3, 1, 32'h9E3779B9);
		random_run(44);
		settle();
		set_ranges(0, 65535, 0, 65535, 32'h0);
		random_run(44);
		settle();
		set_ranges(65535, 65535, 65535, 65535, 32'hA5A5A5A5);
		random_run(20);
		settle();
		set_ranges(2, 7, 1, 6, 32'h00000001);
		random_run(30);
		settle();

		if (fails == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
